@@ sv/abd_pkg.sv @@
// ----------------------------------------------------------------------------
// abd_pkg
// Shared types, codes and constants of the anchor box decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package abd_pkg;

  // item kinds
  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_DECODE = 1'b1;

  // channel codes with a meaning of their own; all others are probabilities
  localparam logic [6:0] CH_X           = 7'd0;
  localparam logic [6:0] CH_Y           = 7'd1;
  localparam logic [6:0] CH_W           = 7'd2;
  localparam logic [6:0] CH_H           = 7'd3;
  localparam logic [6:0] CH_FIRST_CLASS = 7'd4;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_L0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_L1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_L2 = 2'd2;

  localparam logic [6:0] STRIDE_L0_RST = 7'd8;
  localparam logic [6:0] STRIDE_L1_RST = 7'd16;
  localparam logic [6:0] STRIDE_L2_RST = 7'd32;

  // anchor entry: width in the low half, height in the high half
  localparam int unsigned ENTRY_W = 32;

  // Q14.8 output range
  localparam int unsigned VAL_W = 23;
  localparam logic signed [25:0] OUT_MAX = 26'sd4194303;
  localparam logic signed [25:0] OUT_MIN = -26'sd4194304;

  typedef enum logic [1:0] {
    OP_POS,
    OP_WIDTH,
    OP_HEIGHT,
    OP_PROB
  } op_t;

  // piecewise linear sigmoid, Q8.8 in, Q0.8 out (0..256)
  function automatic logic [8:0] sigmoid_q8(input logic signed [15:0] x);
    logic [15:0] a;
    logic [8:0]  f;
    a = x[15] ? 16'(-32'(x)) : 16'(x);
    if (a < 16'd256)
      f = 9'(a >> 2) + 9'd128;
    else if (a < 16'd608)
      f = 9'(a >> 3) + 9'd160;
    else if (a < 16'd1280)
      f = 9'(a >> 5) + 9'd216;
    else
      f = 9'd256;
    return x[15] ? (9'd256 - f) : f;
  endfunction

endpackage

`default_nettype wire

@@ sv/abd_ram.sv @@
// ----------------------------------------------------------------------------
// abd_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module abd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 9,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ sv/anchor_box_decode_top.sv @@
// ----------------------------------------------------------------------------
// anchor_box_decode_top
// Decodes detection head logits into box coordinates, sizes and probabilities.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one item per transfer. A load
//   item writes the anchor width and height of one level and anchor into the
//   anchor RAM and gives no result. A decode item gives one result on the
//   output channel (out_valid / out_stall); an item whose level or anchor is
//   beyond the table gives nothing.
//   Throughput: one item per cycle while in_stall is low. Each decode goes
//   through sigmoid and squaring, anchor RAM read and multiply, rounding
//   and clipping into the output register.
//   The anchor RAM has one write and one read port, both used at the input
//   transfer, so a load is seen by every later decode without forwarding.
//   When the receiver stalls, the output register holds and one more result
//   drops into a skid register; in_stall then rises until the skid drains.
//   Reset sets the strides to 8, 16 and 32 and empties the pipeline; the
//   anchor RAM is not cleared and an entry must be loaded before a width or
//   height channel decodes it. Strides are written on cfg_wr_en; the user
//   must do so only while idle, as the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module anchor_box_decode_top
  import abd_pkg::*;
#(
  parameter int LEVELS            = 3,
  parameter int ANCHORS_PER_LEVEL = 3,
  parameter int GRID_SIZE         = 256
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // configuration
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [6:0]           cfg_wr_data,
  // input channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_kind,
  input  wire logic [1:0]           in_level,
  input  wire logic [1:0]           in_anchor_index,
  input  wire logic [7:0]           in_cell_x,
  input  wire logic [7:0]           in_cell_y,
  input  wire logic [6:0]           in_channel,
  input  wire logic signed [15:0]   in_logit,
  input  wire logic [15:0]          in_anchor_width,
  input  wire logic [15:0]          in_anchor_height,
  // result channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [6:0]                out_channel_out,
  output logic signed [VAL_W-1:0]   out_decoded_value,
  output logic                      out_saturated
);

  localparam int DEPTH = LEVELS * ANCHORS_PER_LEVEL;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam logic [10:0] CELL_MAX = 11'(GRID_SIZE - 1);

  // ---------------------------------------------------------------- config
  logic [6:0] stride_l0_r, stride_l1_r, stride_l2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_l0_r <= STRIDE_L0_RST;
      stride_l1_r <= STRIDE_L1_RST;
      stride_l2_r <= STRIDE_L2_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_STRIDE_L0: stride_l0_r <= cfg_wr_data;
        CFG_STRIDE_L1: stride_l1_r <= cfg_wr_data;
        CFG_STRIDE_L2: stride_l2_r <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // ------------------------------------------------------------ stage 0
  logic            skid_valid_r;
  logic            advance;
  logic            accept;
  logic            in_range;
  logic [3:0]      slot_full;
  logic [AW-1:0]   slot;
  op_t             op;
  logic [7:0]      cell_raw;
  logic [7:0]      cell_sel;
  logic [8:0]      sig;
  logic [9:0]      two_s;
  logic [6:0]      stride;
  logic signed [17:0] pos_base;
  logic [ENTRY_W-1:0] anchor_rd;

  assign advance  = !skid_valid_r;
  assign in_stall = skid_valid_r;
  assign accept   = in_valid && !in_stall;

  assign in_range  = (32'(in_level) < LEVELS) && (32'(in_anchor_index) < ANCHORS_PER_LEVEL);
  assign slot_full = {2'b00, in_level} * 4'(ANCHORS_PER_LEVEL) + {2'b00, in_anchor_index};
  assign slot      = AW'(slot_full);

  always_comb begin
    unique case (in_channel) inside
      CH_X, CH_Y: op = OP_POS;
      CH_W:       op = OP_WIDTH;
      CH_H:       op = OP_HEIGHT;
      default:    op = OP_PROB;
    endcase
  end

  always_comb begin
    unique case (in_level)
      2'd0:    stride = stride_l0_r;
      2'd1:    stride = stride_l1_r;
      default: stride = stride_l2_r;
    endcase
  end

  assign cell_raw = (in_channel == CH_X) ? in_cell_x : in_cell_y;
  assign cell_sel = ({3'b000, cell_raw} > CELL_MAX) ? CELL_MAX[7:0] : cell_raw;
  assign sig      = sigmoid_q8(in_logit);
  assign two_s    = {sig, 1'b0};
  // 2s - 0.5 + cell, all in Q.8
  assign pos_base = $signed({2'b00, cell_sel, 8'h00}) + $signed({8'h00, two_s}) - 18'sd128;

  abd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_anchor_ram (
    .clk     (clk),
    .wr_en   (accept && in_range && (in_kind == KIND_LOAD)),
    .wr_addr (slot),
    .wr_data ({in_anchor_height, in_anchor_width}),
    .rd_en   (accept),
    .rd_addr (slot),
    .rd_data (anchor_rd)
  );

  // ------------------------------------------------------------ stage 1
  logic               s1_valid_r, s1_valid_nxt;
  op_t                s1_op_r;
  logic [6:0]         s1_channel_r;
  logic [8:0]         s1_sig_r;
  logic [18:0]        s1_sq_r;
  logic signed [17:0] s1_base_r;
  logic [6:0]         s1_stride_r;

  assign s1_valid_nxt = advance ? (accept && in_range && (in_kind == KIND_DECODE))
                                : s1_valid_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_op_r      <= op;
      s1_channel_r <= in_channel;
      s1_sig_r     <= sig;
      s1_sq_r      <= 19'(two_s * two_s);
      s1_base_r    <= pos_base;
      s1_stride_r  <= stride;
    end
  end

  logic [15:0] size;
  assign size = (s1_op_r == OP_HEIGHT) ? anchor_rd[31:16] : anchor_rd[15:0];

  // ------------------------------------------------------------ stage 2
  logic               s2_valid_r, s2_valid_nxt;
  op_t                s2_op_r;
  logic [6:0]         s2_channel_r;
  logic [8:0]         s2_sig_r;
  logic signed [25:0] s2_pos_r;
  logic [34:0]        s2_size_r;

  assign s2_valid_nxt = advance ? s1_valid_r : s2_valid_r;

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_op_r      <= s1_op_r;
      s2_channel_r <= s1_channel_r;
      s2_sig_r     <= s1_sig_r;
      s2_pos_r     <= s1_base_r * $signed({1'b0, s1_stride_r});
      s2_size_r    <= 35'(s1_sq_r * size);
    end
  end

  // round Q.20 to Q.8, half up, then clip
  logic [35:0]        size_rnd;
  logic signed [25:0] val;
  logic signed [25:0] val_clip;
  logic               val_sat;

  assign size_rnd = {1'b0, s2_size_r} + 36'd2048;

  always_comb begin
    case (s2_op_r)
      OP_POS:              val = s2_pos_r;
      OP_WIDTH, OP_HEIGHT: val = $signed({2'b00, size_rnd[35:12]});
      default:             val = $signed({17'h0, s2_sig_r});
    endcase
    val_sat  = 1'b1;
    if (val > OUT_MAX)
      val_clip = OUT_MAX;
    else if (val < OUT_MIN)
      val_clip = OUT_MIN;
    else begin
      val_clip = val;
      val_sat  = 1'b0;
    end
  end

  // ----------------------------------------------------- output and skid
  logic                    out_valid_r, out_valid_nxt;
  logic                    skid_valid_nxt;
  logic [6:0]              out_channel_r, skid_channel_r;
  logic signed [VAL_W-1:0] out_value_r, skid_value_r;
  logic                    out_sat_r, skid_sat_r;
  logic                    out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (out_free) begin
      out_valid_nxt  = skid_valid_r || s2_valid_r;
      skid_valid_nxt = 1'b0;
    end else if (s2_valid_r && advance) begin
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid_r) begin
        out_channel_r <= skid_channel_r;
        out_value_r   <= skid_value_r;
        out_sat_r     <= skid_sat_r;
      end else begin
        out_channel_r <= s2_channel_r;
        out_value_r   <= val_clip[VAL_W-1:0];
        out_sat_r     <= val_sat;
      end
    end else if (advance) begin
      // hold the output, park the next result
      skid_channel_r <= s2_channel_r;
      skid_value_r   <= val_clip[VAL_W-1:0];
      skid_sat_r     <= val_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      s2_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      s1_valid_r   <= s1_valid_nxt;
      s2_valid_r   <= s2_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_channel_out   = out_channel_r;
  assign out_decoded_value = out_value_r;
  assign out_saturated     = out_sat_r;

endmodule

`default_nettype wire

@@ sv/abd_checker.sv @@
// ----------------------------------------------------------------------------
// abd_checker
// Port-level checks on the anchor box decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module abd_checker
  import abd_pkg::*;
(
  input wire logic                    clk,
  input wire logic                    rst_n,
  input wire logic                    in_stall,
  input wire logic                    out_valid,
  input wire logic                    out_stall,
  input wire logic [6:0]              out_channel_out,
  input wire logic signed [VAL_W-1:0] out_decoded_value,
  input wire logic                    out_saturated
);

  // a stalled result stays offered
  a_out_valid_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("out_valid dropped while stalled");

  // a stalled result does not change
  a_out_payload_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_channel_out) && $stable(out_decoded_value)
                               && $stable(out_saturated))
    else $error("result changed while stalled");

  // input backpressure only follows a stalled output transfer
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(out_valid && out_stall))
    else $error("in_stall rose without output backpressure");

  // a clipped result sits at one end of the range
  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      (out_decoded_value == OUT_MAX[VAL_W-1:0]) || (out_decoded_value == OUT_MIN[VAL_W-1:0]))
    else $error("saturated result not at range limit");

  // probabilities stay within 0..1 and never clip
  a_prob_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_channel_out >= CH_FIRST_CLASS) |->
      !out_saturated && !out_decoded_value[VAL_W-1] && (out_decoded_value <= 23'sd256))
    else $error("probability out of range");

endmodule

bind anchor_box_decode_top abd_checker u_abd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_channel_out   (out_channel_out),
  .out_decoded_value (out_decoded_value),
  .out_saturated     (out_saturated)
);

`default_nettype wire
